@@ rtl/qkpe_pkg.sv @@
// Shared types and constants for the quadrature knob with press events.
// No dependencies.
package qkpe_pkg;

	localparam int unsigned CfgW    = 16;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned TimerW  = 16;

	localparam logic [CfgW-1:0] DebounceReset  = 16'd150;
	localparam logic [CfgW-1:0] LongPressReset = 16'd40000;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] RegDebounce  = 8'd0;
	localparam logic [CfgIdxW-1:0] RegLongPress = 8'd1;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_REVERSE = 3'd1,
		EV_FORWARD = 3'd2,
		EV_HOLD    = 3'd3,
		EV_RELEASE = 3'd4
	} event_t;

	// phase code: bit0 = phase_a, bit1 = phase_b
	typedef enum logic [1:0] {
		PH_00 = 2'd0,
		PH_A  = 2'd1,
		PH_B  = 2'd2,
		PH_AB = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		PP_IDLE     = 2'd0,
		PP_FIRST    = 2'd1,
		PP_RELEASED = 2'd2,
		PP_SECOND   = 2'd3
	} press_phase_t;

	// one sampled tick as it leaves the input stage
	typedef struct packed {
		logic   en;
		phase_t code;
		logic   push;
	} tick_t;

endpackage

@@ rtl/qkpe_if.sv @@
// Handshake channels: sampled knob ticks in, events out.
// No dependencies.
interface qkpe_tick_if;
	logic valid;
	logic ready;
	logic phase_a;
	logic phase_b;
	logic push_req;

	modport source (output valid, phase_a, phase_b, push_req, input ready);
	modport sink (input valid, phase_a, phase_b, push_req, output ready);
endinterface

interface qkpe_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;

	modport source (output valid, event_res, input ready);
	modport sink (input valid, event_res, output ready);
endinterface

@@ rtl/quadrature_knob_with_press_events.sv @@
// Quadrature knob decoder with debounced push, long-hold and release events.
// A tick is held in the input stage, then its event in the output register.
// Throughput: one tick per cycle; the output register frees itself when taken,
// so ticks keep flowing as long as the event side keeps up.
// Reset (arst_n, async, active low) clears trackers, timers, press phase and
// valid flags; configuration returns to debounce 150, long press 40000.
module quadrature_knob_with_press_events
	import qkpe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	qkpe_tick_if.sink          knob,
	qkpe_event_if.source       evt,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [CfgW-1:0]    cfg_wdata
);

	// configuration registers
	logic [CfgW-1:0] debounce_q;
	logic [CfgW-1:0] long_press_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DebounceReset;
			long_press_q <= LongPressReset;
		end else if (cfg_we) begin
			if (cfg_idx == RegDebounce)  debounce_q   <= cfg_wdata;
			if (cfg_idx == RegLongPress) long_press_q <= cfg_wdata;
		end
	end

	// input stage: holds one sampled tick
	logic   valid_s1;
	phase_t code_s1;
	logic   push_s1;

	// output register: one event waiting for the sink
	logic   out_valid_q;
	event_t event_q;

	logic   advance;
	tick_t  tick;
	event_t ev_nxt;

	// the stage moves whenever the output slot is free or being drained
	assign advance    = valid_s1 && (!out_valid_q || evt.ready);
	assign knob.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (knob.ready) begin
			valid_s1 <= knob.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (knob.ready && knob.valid) begin
			code_s1 <= phase_t'({knob.phase_b, knob.phase_a});
			push_s1 <= knob.push_req;
		end
	end

	assign tick = '{en: advance, code: code_s1, push: push_s1};

	// state update happens exactly once per tick, as it moves to the output
	qkpe_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick             (tick),
		.debounce_ticks   (debounce_q),
		.long_press_ticks (long_press_q),
		.ev               (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= ev_nxt;
		end
	end

	assign evt.valid     = out_valid_q;
	assign evt.event_res = event_q;

endmodule

@@ rtl/qkpe_track.sv @@
// Forward and reverse Gray-sequence trackers, combinational.
// Depends on qkpe_pkg.
module qkpe_track
	import qkpe_pkg::*;
(
	input  logic [1:0] fwd,
	input  logic [1:0] rev,
	input  phase_t     code,
	output logic [1:0] fwd_nxt,
	output logic [1:0] rev_nxt,
	output event_t     ev
);

	logic [1:0] f1;
	logic [1:0] r1;
	event_t     ev1;

	// forward tracker first; its step forces the reverse tracker
	always_comb begin
		f1  = fwd;
		r1  = rev;
		ev1 = EV_NONE;
		if (fwd == 2'd0 && code == PH_00) begin
			f1 = 2'd1; r1 = 2'd2;
		end else if (fwd == 2'd1 && code == PH_B) begin
			f1 = 2'd2; r1 = 2'd1;
		end else if (fwd == 2'd2 && code == PH_AB) begin
			f1 = 2'd3; r1 = 2'd0;
		end else if (fwd == 2'd3 && code == PH_A) begin
			f1 = 2'd0; r1 = 2'd0; ev1 = EV_FORWARD;
		end
	end

	// reverse tracker sees the forward tracker's result
	always_comb begin
		fwd_nxt = f1;
		rev_nxt = r1;
		ev      = ev1;
		if (r1 == 2'd0 && code == PH_B) begin
			rev_nxt = 2'd1; fwd_nxt = 2'd2;
		end else if (r1 == 2'd1 && code == PH_00) begin
			rev_nxt = 2'd2; fwd_nxt = 2'd1;
		end else if (r1 == 2'd2 && code == PH_A) begin
			rev_nxt = 2'd3; fwd_nxt = 2'd0;
		end else if (r1 == 2'd3 && code == PH_AB) begin
			rev_nxt = 2'd0; fwd_nxt = 2'd0; ev = EV_REVERSE;
		end
	end

endmodule

@@ rtl/qkpe_core.sv @@
// Knob state registers and per-tick update: rotation, debounce, hold, release.
// Depends on qkpe_pkg and qkpe_track.
module qkpe_core
	import qkpe_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  tick_t           tick,
	input  logic [CfgW-1:0] debounce_ticks,
	input  logic [CfgW-1:0] long_press_ticks,
	output event_t          ev
);

	logic [1:0]        fwd_q, rev_q;
	logic [TimerW-1:0] timer_q;
	logic              qual_q;
	press_phase_t      phase_q;
	logic [CfgW-1:0]   hold_q;

	logic [1:0]        fwd_trk, rev_trk;
	event_t            ev_trk;

	logic [1:0]        fwd_d, rev_d;
	logic [TimerW-1:0] timer_inc, timer_d;
	logic              qual_d;
	press_phase_t      phase_d;
	logic [CfgW-1:0]   hold_d;
	logic [CfgW:0]     hold_inc;

	qkpe_track u_track (
		.fwd     (fwd_q),
		.rev     (rev_q),
		.code    (tick.code),
		.fwd_nxt (fwd_trk),
		.rev_nxt (rev_trk),
		.ev      (ev_trk)
	);

	assign timer_inc = timer_q + 1'b1;
	assign hold_inc  = {1'b0, hold_q} + 1'b1;

	always_comb begin
		fwd_d   = fwd_q;
		rev_d   = rev_q;
		timer_d = timer_q;
		qual_d  = qual_q;
		phase_d = phase_q;
		hold_d  = hold_q;
		ev      = EV_NONE;

		if (!tick.push) begin
			fwd_d   = fwd_trk;
			rev_d   = rev_trk;
			ev      = ev_trk;
			timer_d = '0;
			qual_d  = 1'b0;
		end else if (timer_inc == debounce_ticks) begin
			timer_d = '0;
			qual_d  = 1'b1;
		end else begin
			timer_d = timer_inc;
		end

		if (qual_d) begin
			// any qualified tick lands in a held phase
			case (phase_q)
				PP_IDLE:     phase_d = PP_FIRST;
				PP_RELEASED: phase_d = PP_SECOND;
				default:     phase_d = phase_q;
			endcase
			if (hold_inc >= {1'b0, long_press_ticks}) begin
				ev     = EV_HOLD;
				hold_d = long_press_ticks;
			end else begin
				hold_d = hold_inc[CfgW-1:0];
			end
		end else begin
			hold_d = '0;
			if (phase_q == PP_FIRST || phase_q == PP_SECOND) begin
				phase_d = (phase_q == PP_FIRST) ? PP_RELEASED : PP_IDLE;
				ev      = EV_RELEASE;
				fwd_d   = 2'd0;
				rev_d   = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q   <= 2'd0;
			rev_q   <= 2'd0;
			timer_q <= '0;
			qual_q  <= 1'b0;
			phase_q <= PP_IDLE;
			hold_q  <= '0;
		end else if (tick.en) begin
			fwd_q   <= fwd_d;
			rev_q   <= rev_d;
			timer_q <= timer_d;
			qual_q  <= qual_d;
			phase_q <= phase_d;
			hold_q  <= hold_d;
		end
	end

endmodule
